// ===== rtl/dfc_pkg.sv =====
// shared types and constants for the delayed feedback controller
package dfc_pkg;

    // history store geometry
    localparam int HISTORY_DEPTH = 1024;
    localparam int HIST_AW       = $clog2(HISTORY_DEPTH);

    // register widths
    localparam int DELAY_W = 11;
    localparam int GAIN_W  = 16;
    localparam int CFG_W   = 16;
    localparam int CFG_AW  = 2;

    // width for pointer and delay arithmetic, holds the depth itself
    localparam int CALC_W = ((HIST_AW > DELAY_W) ? HIST_AW : DELAY_W) + 1;

    // sample and arithmetic widths
    localparam int SAMPLE_W = 16;
    localparam int DIFF_W   = SAMPLE_W + 1;
    localparam int PROD_W   = DIFF_W + GAIN_W;
    localparam int FRAC_SH  = 8;
    localparam int Q_W      = PROD_W - FRAC_SH;

    // reset values of the registers
    localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(1);
    localparam logic [GAIN_W-1:0]  GAIN_RESET  = GAIN_W'(256);

    // register indexes
    typedef enum logic [CFG_AW-1:0] {
        REG_LAG_SAMPLES   = 2'd0,
        REG_FEEDBACK_GAIN = 2'd1
    } t_reg_index;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [HIST_AW-1:0]         t_hist_addr;

endpackage

// ===== rtl/delayed_feedback_controller_unit.sv =====
// delayed feedback controller: history store, difference, gain and saturation
//
// Input channel: i_valid / o_stall carry one sample item; it is taken at a
// rising edge with i_valid high and o_stall low. Output channel: o_valid /
// i_stall carry one result item (o_control_value, o_saturated) per sample.
// Configuration: i_cfg_we with i_cfg_index selects the lag in samples (0) or
// feedback_gain (1); other indexes are ignored. Write only while idle.
// An accepted sample is registered in the read stage and then in the output
// register, where o_valid rises; one item per cycle is sustained while the
// receiver does not stall, set by the single read and single write of the
// history memory per cycle and one 17 x 16 multiply in the result stage.
// The history memory is not swept at reset: a wrap flag and the write
// pointer tell which entries have been written, and unwritten entries read
// as zero, so items are accepted from the first cycle after reset.
// Reset (synchronous, active low) empties the pipeline, sets the write
// pointer to zero, the delay to one step and the gain to 1.0.
// When the receiver stalls, the result is held in the output register, the
// read stage holds its item, and o_stall rises only once both are full.
module delayed_feedback_controller_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [dfc_pkg::SAMPLE_W-1:0] i_sample,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [dfc_pkg::SAMPLE_W-1:0] o_control_value,
    output logic                              o_saturated,
    input  logic                              i_cfg_we,
    input  logic [dfc_pkg::CFG_AW-1:0]        i_cfg_index,
    input  logic [dfc_pkg::CFG_W-1:0]         i_cfg_data
);

    localparam logic [dfc_pkg::CALC_W-1:0] DEPTH_C = dfc_pkg::CALC_W'(dfc_pkg::HISTORY_DEPTH);
    localparam logic [dfc_pkg::HIST_AW-1:0] LAST_ADDR =
        dfc_pkg::HIST_AW'(dfc_pkg::HISTORY_DEPTH - 1);
    localparam logic signed [dfc_pkg::Q_W-1:0] Q_MAX = dfc_pkg::Q_W'(32767);
    localparam logic signed [dfc_pkg::Q_W-1:0] Q_MIN = -(dfc_pkg::Q_W'(32768));

    // configuration registers
    logic [dfc_pkg::DELAY_W-1:0]      r_delay;
    logic signed [dfc_pkg::GAIN_W-1:0] r_gain;

    // history store and pointer state
    dfc_pkg::t_sample    r_hist [dfc_pkg::HISTORY_DEPTH];
    dfc_pkg::t_hist_addr r_wp;
    dfc_pkg::t_hist_addr n_wp;
    logic                r_wrapped;

    // read stage
    logic                r_s1_valid;
    logic                r_s1_past_ok;
    dfc_pkg::t_sample    r_s1_cur;
    dfc_pkg::t_sample    r_rdata;

    // output stage
    logic                r_out_valid;
    dfc_pkg::t_sample    r_out_value;
    logic                r_out_sat;

    logic                          w_out_free;
    logic                          w_in_accept;
    logic [dfc_pkg::CALC_W-1:0]    w_delay_ext;
    logic [dfc_pkg::CALC_W-1:0]    w_delay_mod;
    logic [dfc_pkg::CALC_W-1:0]    w_wp_ext;
    logic [dfc_pkg::CALC_W-1:0]    w_rd_ext;
    dfc_pkg::t_hist_addr           w_rd_addr;
    logic                          w_rd_written;
    dfc_pkg::t_sample              w_past;
    logic signed [dfc_pkg::DIFF_W-1:0] w_diff;
    logic signed [dfc_pkg::PROD_W-1:0] w_prod;
    logic signed [dfc_pkg::Q_W-1:0]    w_q;
    dfc_pkg::t_sample              n_out_value;
    logic                          n_out_sat;

    // handshake: stages advance when the next one is free
    assign w_out_free  = !r_out_valid || !i_stall;
    assign o_stall     = r_s1_valid && !w_out_free;
    assign w_in_accept = i_valid && !o_stall;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay <= dfc_pkg::DELAY_RESET;
            r_gain  <= dfc_pkg::GAIN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                dfc_pkg::REG_LAG_SAMPLES:   r_delay <= i_cfg_data[dfc_pkg::DELAY_W-1:0];
                dfc_pkg::REG_FEEDBACK_GAIN: r_gain  <= i_cfg_data[dfc_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // read address: delay clamped to the depth, a full depth reads the slot about to be written
    always_comb begin
        w_delay_ext = dfc_pkg::CALC_W'(r_delay);
        w_delay_mod = (w_delay_ext >= DEPTH_C) ? '0 : w_delay_ext;
        w_wp_ext    = dfc_pkg::CALC_W'(r_wp);
        if (w_wp_ext >= w_delay_mod) begin
            w_rd_ext = w_wp_ext - w_delay_mod;
        end else begin
            w_rd_ext = w_wp_ext + DEPTH_C - w_delay_mod;
        end
        w_rd_addr    = w_rd_ext[dfc_pkg::HIST_AW-1:0];
        w_rd_written = r_wrapped || (w_rd_addr < r_wp);
        n_wp         = (r_wp == LAST_ADDR) ? '0 : r_wp + dfc_pkg::HIST_AW'(1);
    end

    // history memory: read before write at the same edge
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_rdata        <= r_hist[w_rd_addr];
            r_hist[r_wp]   <= i_sample;
            r_s1_cur       <= i_sample;
            r_s1_past_ok   <= w_rd_written;
        end
    end

    // write pointer, wrap flag and read stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp       <= '0;
            r_wrapped  <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            if (w_in_accept) begin
                r_wp <= n_wp;
                if (r_wp == LAST_ADDR) begin
                    r_wrapped <= 1'b1;
                end
            end
            if (w_in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_out_free) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // difference, gain, floor shift and saturation
    always_comb begin
        w_past = r_s1_past_ok ? r_rdata : '0;
        w_diff = dfc_pkg::DIFF_W'(w_past) - dfc_pkg::DIFF_W'(r_s1_cur);
        w_prod = dfc_pkg::PROD_W'(w_diff) * dfc_pkg::PROD_W'(r_gain);
        w_q    = w_prod[dfc_pkg::PROD_W-1:dfc_pkg::FRAC_SH];
        priority if (w_q > Q_MAX) begin
            n_out_value = dfc_pkg::SAMPLE_W'(Q_MAX);
            n_out_sat   = 1'b1;
        end else if (w_q < Q_MIN) begin
            n_out_value = dfc_pkg::SAMPLE_W'(Q_MIN);
            n_out_sat   = 1'b1;
        end else begin
            n_out_value = w_q[dfc_pkg::SAMPLE_W-1:0];
            n_out_sat   = 1'b0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && r_s1_valid) begin
            r_out_value <= n_out_value;
            r_out_sat   <= n_out_sat;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_control_value = r_out_value;
    assign o_saturated     = r_out_sat;

    // checks on pipeline and store bookkeeping
    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_s1_valid && r_out_valid))
        else $error("input stalled without both stages full");

    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |=> r_s1_valid)
        else $error("accepted item missing from read stage");

    a_s1_moves_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && w_out_free) |=> r_out_valid)
        else $error("read stage item lost on its way to the output");

    a_wrap_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wrapped |=> r_wrapped)
        else $error("wrap flag cleared outside reset");

    a_sat_clips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |->
            (o_control_value == 16'sh7FFF || o_control_value == 16'sh8000))
        else $error("saturation flag without a clipped value");

endmodule
